### rtl/htiu_pkg.sv
// Shared types, codes and timer tables of the timer and interrupt unit.
package htiu_pkg;

  localparam logic [2:0] FUNC_TICK  = 3'd0;
  localparam logic [2:0] FUNC_CHECK = 3'd1;
  localparam logic [2:0] FUNC_WRITE = 3'd2;
  localparam logic [2:0] FUNC_READ  = 3'd3;
  localparam logic [2:0] FUNC_RAISE = 3'd4;

  localparam logic [2:0] REG_IF   = 3'd0;
  localparam logic [2:0] REG_IE   = 3'd1;
  localparam logic [2:0] REG_IME  = 3'd2;
  localparam logic [2:0] REG_TAC  = 3'd3;
  localparam logic [2:0] REG_TMA  = 3'd4;
  localparam logic [2:0] REG_TIMA = 3'd5;
  localparam logic [2:0] REG_DIV  = 3'd6;

  localparam logic [7:0] VEC_BASE        = 8'h40;
  localparam logic [4:0] DISPATCH_CYCLES = 5'd20;
  localparam int unsigned TIMER_IRQ_BIT  = 2;

  typedef struct packed {
    logic [2:0]  func;
    logic [7:0]  tick_count;
    logic [15:0] program_counter;
    logic [15:0] stack_pointer;
    logic        ei_delay;
    logic [2:0]  reg_select;
    logic [7:0]  write_data;
    logic [4:0]  irq_request;
  } in_item_t;

  typedef struct packed {
    logic        kind;
    logic [15:0] stack_addr;
    logic [7:0]  stack_data;
    logic [15:0] new_pc;
    logic [15:0] new_sp;
    logic        taken;
    logic [4:0]  cycles_used;
    logic [7:0]  read_data;
    logic [7:0]  div_value;
    logic [7:0]  timer_value;
    logic [4:0]  irq_flags;
    logic        last;
  } out_item_t;

  typedef enum logic [1:0] {
    PH_STATUS,
    PH_PUSH_HI,
    PH_PUSH_LO
  } phase_e;

  typedef struct packed {
    logic   load;
    logic   step;
    phase_e phase;
  } cmd_t;

  typedef struct packed {
    logic start_ticks;
    logic start_dispatch;
    logic ticks_last;
  } sts_t;

  // Last prescaler count of a timer period, per TAC[1:0].
  function automatic logic [9:0] rate_last(input logic [1:0] rate);
    logic [9:0] r;
    unique case (rate)
      2'd0: r = 10'd1023;
      2'd1: r = 10'd15;
      2'd2: r = 10'd63;
      default: r = 10'd255;
    endcase
    return r;
  endfunction

endpackage

### rtl/htiu_in_if.sv
// Request channel carrying one input item.
interface htiu_in_if
  import htiu_pkg::*;
;
  logic     valid;
  logic     ready;
  in_item_t data;

  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

### rtl/htiu_out_if.sv
// Result channel carrying one result item.
interface htiu_out_if
  import htiu_pkg::*;
;
  logic      valid;
  logic      ready;
  out_item_t data;

  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

### rtl/htiu_ctrl.sv
// Controller sequencing request intake, tick stepping and result delivery.
module htiu_ctrl
  import htiu_pkg::*;
(
  input  logic clk_i,
  input  logic rst_ni,
  input  logic in_valid_i,
  output logic in_ready_o,
  output logic out_valid_o,
  input  logic out_ready_i,
  input  sts_t sts_i,
  output cmd_t cmd_o
);

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_TICK,
    ST_RESULT
  } state_e;

  state_e state_q;
  phase_e phase_q;
  logic   in_ready_q;
  logic   out_valid_q;

  assign in_ready_o  = in_ready_q;
  assign out_valid_o = out_valid_q;

  always_comb begin
    cmd_o.load  = in_valid_i & in_ready_q;
    cmd_o.step  = (state_q == ST_TICK);
    cmd_o.phase = phase_q;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      phase_q     <= PH_STATUS;
      in_ready_q  <= 1'b1;
      out_valid_q <= 1'b0;
    end else begin
      unique case (state_q)
        ST_IDLE: begin
          if (in_valid_i && in_ready_q) begin
            in_ready_q <= 1'b0;
            priority if (sts_i.start_ticks) begin
              state_q <= ST_TICK;
            end else if (sts_i.start_dispatch) begin
              state_q     <= ST_RESULT;
              phase_q     <= PH_PUSH_HI;
              out_valid_q <= 1'b1;
            end else begin
              state_q     <= ST_RESULT;
              phase_q     <= PH_STATUS;
              out_valid_q <= 1'b1;
            end
          end
        end
        ST_TICK: begin
          // advance one cycle per clock until the count runs out
          if (sts_i.ticks_last) begin
            state_q     <= ST_RESULT;
            phase_q     <= PH_STATUS;
            out_valid_q <= 1'b1;
          end
        end
        ST_RESULT: begin
          if (out_ready_i) begin
            if (phase_q == PH_PUSH_HI) begin
              phase_q <= PH_PUSH_LO;
            end else begin
              state_q     <= ST_IDLE;
              phase_q     <= PH_STATUS;
              out_valid_q <= 1'b0;
              in_ready_q  <= 1'b1;
            end
          end
        end
        default: begin
          state_q     <= ST_IDLE;
          phase_q     <= PH_STATUS;
          out_valid_q <= 1'b0;
          in_ready_q  <= 1'b1;
        end
      endcase
    end
  end

endmodule

### rtl/htiu_dp.sv
// Datapath: divider, timer, interrupt registers and result formatting.
module htiu_dp
  import htiu_pkg::*;
(
  input  logic      clk_i,
  input  logic      rst_ni,
  input  in_item_t  item_i,
  input  cmd_t      cmd_i,
  output sts_t      sts_o,
  output out_item_t result_o
);

  logic [15:0] div_q;
  logic [9:0]  presc_q;
  logic [7:0]  tima_q;
  logic [7:0]  tma_q;
  logic [2:0]  tac_q;
  logic [4:0]  if_q;
  logic [4:0]  ie_q;
  logic        ime_q;

  logic [7:0]  ticks_q;
  logic [15:0] pc_q;
  logic [15:0] sp_q;
  logic [7:0]  vec_q;
  logic [7:0]  rd_q;
  logic        check_q;

  logic [4:0]  pend;
  logic [2:0]  irq_bit;
  logic [7:0]  read_val;
  logic [15:0] sp_m1;
  logic [15:0] sp_m2;

  assign pend = if_q & ie_q;

  // lowest pending enabled source wins
  always_comb begin
    priority if (pend[0]) irq_bit = 3'd0;
    else if (pend[1]) irq_bit = 3'd1;
    else if (pend[2]) irq_bit = 3'd2;
    else if (pend[3]) irq_bit = 3'd3;
    else irq_bit = 3'd4;
  end

  always_comb begin
    unique case (item_i.reg_select)
      REG_IF:   read_val = {3'b000, if_q};
      REG_IE:   read_val = {3'b000, ie_q};
      REG_IME:  read_val = {7'd0, ime_q};
      REG_TAC:  read_val = {5'd0, tac_q};
      REG_TMA:  read_val = tma_q;
      REG_TIMA: read_val = tima_q;
      REG_DIV:  read_val = div_q[15:8];
      default:  read_val = 8'd0;
    endcase
  end

  always_comb begin
    sts_o.start_ticks    = (item_i.func == FUNC_TICK) && (item_i.tick_count != 8'd0);
    sts_o.start_dispatch = (item_i.func == FUNC_CHECK) && !item_i.ei_delay && ime_q
                           && (pend != 5'd0);
    sts_o.ticks_last     = (ticks_q == 8'd1);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      div_q   <= '0;
      presc_q <= '0;
      tima_q  <= '0;
      tma_q   <= '0;
      tac_q   <= '0;
      if_q    <= '0;
      ie_q    <= '0;
      ime_q   <= 1'b0;
    end else if (cmd_i.step) begin
      div_q <= div_q + 16'd1;
      if (tac_q[2]) begin
        if (presc_q >= rate_last(tac_q[1:0])) begin
          presc_q <= '0;
          if (tima_q == 8'hFF) begin
            tima_q                <= tma_q;
            if_q[TIMER_IRQ_BIT]   <= 1'b1;
          end else begin
            tima_q <= tima_q + 8'd1;
          end
        end else begin
          presc_q <= presc_q + 10'd1;
        end
      end
    end else if (cmd_i.load) begin
      priority case (item_i.func)
        FUNC_CHECK: begin
          if (sts_o.start_dispatch) begin
            if_q[irq_bit] <= 1'b0;
            ime_q         <= 1'b0;
          end
        end
        FUNC_WRITE: begin
          priority case (item_i.reg_select)
            REG_IF:   if_q   <= item_i.write_data[4:0];
            REG_IE:   ie_q   <= item_i.write_data[4:0];
            REG_IME:  ime_q  <= item_i.write_data[0];
            REG_TAC:  tac_q  <= item_i.write_data[2:0];
            REG_TMA:  tma_q  <= item_i.write_data;
            REG_TIMA: tima_q <= item_i.write_data;
            default: ;
          endcase
        end
        FUNC_RAISE: if_q <= if_q | item_i.irq_request;
        default: ;
      endcase
    end
  end

  // item registers: hold the fields the results need
  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      ticks_q <= item_i.tick_count;
      pc_q    <= item_i.program_counter;
      sp_q    <= item_i.stack_pointer;
      vec_q   <= VEC_BASE + {2'b00, irq_bit, 3'b000};
      rd_q    <= (item_i.func == FUNC_READ) ? read_val : 8'd0;
      check_q <= (item_i.func == FUNC_CHECK);
    end else if (cmd_i.step) begin
      ticks_q <= ticks_q - 8'd1;
    end
  end

  assign sp_m1 = sp_q - 16'd1;
  assign sp_m2 = sp_q - 16'd2;

  always_comb begin
    result_o.div_value   = div_q[15:8];
    result_o.timer_value = tima_q;
    result_o.irq_flags   = if_q;
    unique case (cmd_i.phase)
      PH_PUSH_HI, PH_PUSH_LO: begin
        result_o.kind        = 1'b1;
        result_o.stack_addr  = (cmd_i.phase == PH_PUSH_HI) ? sp_m1 : sp_m2;
        result_o.stack_data  = (cmd_i.phase == PH_PUSH_HI) ? pc_q[15:8] : pc_q[7:0];
        result_o.new_pc      = {8'd0, vec_q};
        result_o.new_sp      = sp_m2;
        result_o.taken       = 1'b1;
        result_o.cycles_used = DISPATCH_CYCLES;
        result_o.read_data   = 8'd0;
        result_o.last        = (cmd_i.phase == PH_PUSH_LO);
      end
      default: begin
        result_o.kind        = 1'b0;
        result_o.stack_addr  = 16'd0;
        result_o.stack_data  = 8'd0;
        result_o.new_pc      = check_q ? pc_q : 16'd0;
        result_o.new_sp      = check_q ? sp_q : 16'd0;
        result_o.taken       = 1'b0;
        result_o.cycles_used = 5'd0;
        result_o.read_data   = rd_q;
        result_o.last        = 1'b1;
      end
    endcase
  end

endmodule

### rtl/handheld_timer_interrupt_unit_top.sv
// Top level of the handheld timer and interrupt unit.
//
// Requests arrive on in_i and results leave on out_o, both valid/ready
// channels; an item moves at a clock edge with valid and ready high.
// One request is in flight at a time. After a request is taken, in_i.ready
// stays low until its last result has been taken.
// A tick request steps the divider and timer once per clock, so its result
// is valid once the stepping loop has run out the tick count, and no new
// request is taken meanwhile. A tick request with a zero count and all other
// requests give their result in the cycle after the request is taken; an
// interrupt dispatch gives two stack write results, PC high byte
// first, the second marked last.
// When out_o.ready is low the result holds and nothing advances; the next
// request is taken the cycle after the last result leaves.
// Reset clears the divider, timer and interrupt registers to zero, with
// master enable off and the unit ready for a request.
module handheld_timer_interrupt_unit_top
  import htiu_pkg::*;
(
  input  logic       clk_i,
  input  logic       rst_ni,
  htiu_in_if.sink    in_i,
  htiu_out_if.source out_o
);

  cmd_t      cmd;
  sts_t      sts;
  logic      in_ready;
  logic      out_valid;
  out_item_t result;

  htiu_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_i.valid),
    .in_ready_o  (in_ready),
    .out_valid_o (out_valid),
    .out_ready_i (out_o.ready),
    .sts_i       (sts),
    .cmd_o       (cmd)
  );

  htiu_dp u_dp (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .item_i   (in_i.data),
    .cmd_i    (cmd),
    .sts_o    (sts),
    .result_o (result)
  );

  assign in_i.ready  = in_ready;
  assign out_o.valid = out_valid;
  assign out_o.data  = result;

endmodule

### bench/tb_handheld_timer_interrupt_unit_top.sv
// Self-checking testbench of the handheld timer and interrupt unit top level.
module tb_handheld_timer_interrupt_unit_top
  import htiu_pkg::*;
;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned WATCHDOG_LIMIT = 4000;
  localparam int unsigned ITEMS_PER_PHASE = 390;
  localparam int unsigned SETTLE_CYCLES = 300;

  logic clk_i;
  logic rst_ni;

  htiu_in_if  req_if ();
  htiu_out_if res_if ();

  handheld_timer_interrupt_unit_top dut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .in_i   (req_if),
    .out_o  (res_if)
  );

  // Shadow copy of the unit's registers.
  logic [15:0] div_cnt;
  logic [9:0]  pre_cnt;
  logic [7:0]  tima;
  logic [7:0]  tma;
  logic [2:0]  tac;
  logic [4:0]  iflag;
  logic [4:0]  ienable;
  logic        ime;

  in_item_t  request_queue[$];
  out_item_t pending_results[$];
  out_item_t due_result;

  int unsigned send_idle_pct;
  int unsigned recv_stall_pct;
  int unsigned error_count;
  int unsigned stall_cycles;
  int unsigned queued_count;

  always begin
    #10 clk_i = 1'b1;
    #10 clk_i = 1'b0;
  end

  // One clock of the divider, prescaler and TIMA.
  task automatic step_cycle();
    logic [9:0] period_last;
    div_cnt = div_cnt + 16'd1;
    if (tac[2]) begin
      case (tac[1:0])
        2'd0:    period_last = 10'd1023;
        2'd1:    period_last = 10'd15;
        2'd2:    period_last = 10'd63;
        default: period_last = 10'd255;
      endcase
      if (pre_cnt >= period_last) begin
        pre_cnt = '0;
        if (tima == 8'hFF) begin
          tima = tma;
          iflag[TIMER_IRQ_BIT] = 1'b1;
        end else begin
          tima = tima + 8'd1;
        end
      end else begin
        pre_cnt = pre_cnt + 10'd1;
      end
    end
  endtask

  // Update the shadow registers for one request and queue the results it causes.
  task automatic apply_request(input in_item_t r);
    out_item_t   res;
    logic [4:0]  pend;
    int unsigned bit_idx;
    logic        dispatched;
    res = '0;
    dispatched = 1'b0;
    case (r.func)
      FUNC_TICK: repeat (r.tick_count) step_cycle();
      FUNC_CHECK: begin
        pend = iflag & ienable;
        if (!r.ei_delay && ime && pend != 5'd0) begin
          bit_idx = 0;
          while (bit_idx < 4 && !pend[bit_idx]) bit_idx++;
          iflag[bit_idx] = 1'b0;
          ime = 1'b0;
          dispatched = 1'b1;
          res.kind        = 1'b1;
          res.stack_addr  = r.stack_pointer - 16'd1;
          res.stack_data  = r.program_counter[15:8];
          res.new_pc      = 16'(VEC_BASE) + 16'(8 * bit_idx);
          res.new_sp      = r.stack_pointer - 16'd2;
          res.taken       = 1'b1;
          res.cycles_used = DISPATCH_CYCLES;
          res.div_value   = div_cnt[15:8];
          res.timer_value = tima;
          res.irq_flags   = iflag;
          res.last        = 1'b0;
          pending_results.push_back(res);
          res.stack_addr  = r.stack_pointer - 16'd2;
          res.stack_data  = r.program_counter[7:0];
          res.last        = 1'b1;
          pending_results.push_back(res);
        end else begin
          res.new_pc = r.program_counter;
          res.new_sp = r.stack_pointer;
        end
      end
      FUNC_WRITE: begin
        case (r.reg_select)
          REG_IF:   iflag   = r.write_data[4:0];
          REG_IE:   ienable = r.write_data[4:0];
          REG_IME:  ime     = r.write_data[0];
          REG_TAC:  tac     = r.write_data[2:0];
          REG_TMA:  tma     = r.write_data;
          REG_TIMA: tima    = r.write_data;
          default: ;
        endcase
      end
      FUNC_READ: begin
        case (r.reg_select)
          REG_IF:   res.read_data = {3'b000, iflag};
          REG_IE:   res.read_data = {3'b000, ienable};
          REG_IME:  res.read_data = {7'd0, ime};
          REG_TAC:  res.read_data = {5'd0, tac};
          REG_TMA:  res.read_data = tma;
          REG_TIMA: res.read_data = tima;
          REG_DIV:  res.read_data = div_cnt[15:8];
          default:  res.read_data = 8'd0;
        endcase
      end
      FUNC_RAISE: iflag = iflag | r.irq_request;
      default: ;
    endcase
    if (!dispatched) begin
      res.div_value   = div_cnt[15:8];
      res.timer_value = tima;
      res.irq_flags   = iflag;
      res.last        = 1'b1;
      pending_results.push_back(res);
    end
  endtask

  function automatic in_item_t random_fields();
    in_item_t r;
    r.func            = 3'($urandom_range(7));
    r.tick_count      = 8'($urandom);
    r.program_counter = 16'($urandom);
    r.stack_pointer   = 16'($urandom);
    r.ei_delay        = 1'($urandom);
    r.reg_select      = 3'($urandom_range(7));
    r.write_data      = 8'($urandom);
    r.irq_request     = 5'($urandom);
    return r;
  endfunction

  // Queue a request whose meaningful fields are a and b; the rest stay random.
  task automatic queue_op(input logic [2:0] f, input logic [7:0] a, input logic [7:0] b);
    in_item_t r;
    r = random_fields();
    r.func = f;
    case (f)
      FUNC_TICK:  r.tick_count = a;
      FUNC_WRITE: begin
        r.reg_select = a[2:0];
        r.write_data = b;
      end
      FUNC_READ:  r.reg_select = a[2:0];
      FUNC_RAISE: r.irq_request = a[4:0];
      default: ;
    endcase
    request_queue.push_back(r);
    queued_count++;
  endtask

  task automatic queue_check(input logic [15:0] pc, input logic [15:0] sp, input logic eid);
    in_item_t r;
    r = random_fields();
    r.func            = FUNC_CHECK;
    r.program_counter = pc;
    r.stack_pointer   = sp;
    r.ei_delay        = eid;
    request_queue.push_back(r);
    queued_count++;
  endtask

  task automatic queue_random_request();
    in_item_t    r;
    int unsigned pick;
    r = random_fields();
    pick = $urandom_range(99);
    if (pick < 30) begin
      r.func = FUNC_TICK;
      pick = $urandom_range(99);
      if (pick < 60)      r.tick_count = 8'($urandom_range(31));
      else if (pick < 90) r.tick_count = 8'($urandom_range(127, 32));
      else                r.tick_count = 8'($urandom_range(255, 128));
    end else if (pick < 55) begin
      r.func = FUNC_CHECK;
      r.ei_delay = ($urandom_range(3) == 0);
    end else if (pick < 80) begin
      r.func = FUNC_WRITE;
      pick = $urandom_range(99);
      if (pick < 30) begin
        r.reg_select = REG_IME;
        r.write_data[0] = ($urandom_range(9) < 8);
      end else if (pick < 45) begin
        r.reg_select = REG_TAC;
        r.write_data[2] = ($urandom_range(9) < 8);
      end else if (pick < 60) begin
        r.reg_select = REG_TIMA;
        if ($urandom_range(1)) r.write_data[7:4] = 4'hF;
      end
    end else if (pick < 90) begin
      r.func = FUNC_READ;
    end else if (pick < 96) begin
      r.func = FUNC_RAISE;
    end else begin
      r.func = 3'($urandom_range(7, 5));
    end
    request_queue.push_back(r);
    queued_count++;
  endtask

  // Raise, enable and arm an interrupt, then check at an instruction boundary.
  task automatic queue_dispatch_sequence();
    queue_op(FUNC_RAISE, 8'($urandom_range(31, 1)), 8'd0);
    queue_op(FUNC_WRITE, 8'(REG_IE), 8'($urandom) | (8'd1 << $urandom_range(4)));
    queue_op(FUNC_WRITE, 8'(REG_IME), 8'($urandom) | 8'd1);
    if ($urandom_range(1)) queue_op(FUNC_TICK, 8'($urandom_range(40)), 8'd0);
    queue_check(16'($urandom), 16'($urandom), 1'b0);
  endtask

  task automatic wait_drained();
    while (request_queue.size() != 0 || req_if.valid || pending_results.size() != 0)
      @(posedge clk_i);
  endtask

  task automatic check_field(input string name, input logic [15:0] exp_v,
                             input logic [15:0] act_v);
    if (exp_v !== act_v) begin
      $error("%s mismatch: expected %0h, got %0h", name, exp_v, act_v);
      error_count++;
    end
  endtask

  // Request driver: present queued requests, idling at random.
  always @(posedge clk_i) begin
    if (!rst_ni) begin
      req_if.valid <= 1'b0;
    end else begin
      if (req_if.valid && req_if.ready) apply_request(req_if.data);
      if (!req_if.valid || req_if.ready) begin
        if (request_queue.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
          req_if.data  <= request_queue.pop_front();
          req_if.valid <= 1'b1;
        end else begin
          req_if.valid <= 1'b0;
        end
      end
    end
  end

  // Result monitor: compare against the oldest expectation, stall at random.
  always @(posedge clk_i) begin
    if (!rst_ni) begin
      res_if.ready <= 1'b0;
    end else begin
      if (res_if.valid && res_if.ready) begin
        if (pending_results.size() == 0) begin
          $error("result arrived with no expectation pending");
          error_count++;
        end else begin
          due_result = pending_results.pop_front();
          check_field("kind", 16'(due_result.kind), 16'(res_if.data.kind));
          check_field("stack_addr", due_result.stack_addr, res_if.data.stack_addr);
          check_field("stack_data", 16'(due_result.stack_data), 16'(res_if.data.stack_data));
          check_field("new_pc", due_result.new_pc, res_if.data.new_pc);
          check_field("new_sp", due_result.new_sp, res_if.data.new_sp);
          check_field("taken", 16'(due_result.taken), 16'(res_if.data.taken));
          check_field("cycles_used", 16'(due_result.cycles_used),
                      16'(res_if.data.cycles_used));
          check_field("read_data", 16'(due_result.read_data), 16'(res_if.data.read_data));
          check_field("div_value", 16'(due_result.div_value), 16'(res_if.data.div_value));
          check_field("timer_value", 16'(due_result.timer_value),
                      16'(res_if.data.timer_value));
          check_field("irq_flags", 16'(due_result.irq_flags), 16'(res_if.data.irq_flags));
          check_field("last", 16'(due_result.last), 16'(res_if.data.last));
        end
      end
      res_if.ready <= ($urandom_range(99) >= recv_stall_pct);
    end
  end

  // Watchdog on cycles without any transfer.
  always @(posedge clk_i) begin
    if (!rst_ni || (req_if.valid && req_if.ready) || (res_if.valid && res_if.ready)) begin
      stall_cycles <= 0;
    end else if (stall_cycles >= WATCHDOG_LIMIT) begin
      $display("** handheld_timer_interrupt_unit_top: FAILED **");
      $finish;
    end else begin
      stall_cycles <= stall_cycles + 1;
    end
  end

  initial begin
    clk_i          = 1'b0;
    rst_ni         = 1'b0;
    req_if.valid   = 1'b0;
    req_if.data    = '0;
    res_if.ready   = 1'b0;
    send_idle_pct  = 0;
    recv_stall_pct = 0;
    error_count    = 0;
    stall_cycles   = 0;
    queued_count   = 0;
    div_cnt = '0;
    pre_cnt = '0;
    tima    = '0;
    tma     = '0;
    tac     = '0;
    iflag   = '0;
    ienable = '0;
    ime     = 1'b0;

    repeat (5) @(posedge clk_i);
    rst_ni <= 1'b1;

    // Directed: counter extremes, ignored writes, masking, overflow, rate change.
    queue_op(FUNC_TICK, 8'd0, 8'd0);
    queue_op(FUNC_TICK, 8'd255, 8'd0);
    queue_op(FUNC_TICK, 8'd255, 8'd0);
    queue_op(FUNC_READ, 8'(REG_DIV), 8'd0);
    queue_op(FUNC_WRITE, 8'(REG_DIV), 8'hFF);
    queue_op(FUNC_WRITE, 8'd7, 8'hAA);
    queue_op(FUNC_READ, 8'd7, 8'd0);
    queue_op(FUNC_WRITE, 8'(REG_TMA), 8'hFF);
    queue_op(FUNC_WRITE, 8'(REG_TIMA), 8'hFE);
    queue_op(FUNC_WRITE, 8'(REG_TAC), 8'hFD);
    queue_op(FUNC_TICK, 8'd40, 8'd0);
    queue_op(FUNC_READ, 8'(REG_TIMA), 8'd0);
    queue_op(FUNC_WRITE, 8'(REG_TAC), 8'h07);
    queue_op(FUNC_TICK, 8'd100, 8'd0);
    queue_op(FUNC_WRITE, 8'(REG_TAC), 8'h05);
    queue_op(FUNC_TICK, 8'd1, 8'd0);
    queue_op(FUNC_WRITE, 8'(REG_IF), 8'hFF);
    queue_op(FUNC_WRITE, 8'(REG_IE), 8'hE0);
    queue_op(FUNC_WRITE, 8'(REG_IME), 8'hFE);
    queue_op(FUNC_READ, 8'(REG_IF), 8'd0);
    queue_op(FUNC_READ, 8'(REG_IME), 8'd0);
    queue_op(FUNC_RAISE, 8'h1F, 8'd0);
    queue_op(FUNC_WRITE, 8'(REG_IE), 8'h1F);
    queue_op(FUNC_WRITE, 8'(REG_IME), 8'h01);
    // Suppressed by the EI delay, then taken with the stack wrapping below zero.
    queue_check(16'hFFFF, 16'h0000, 1'b1);
    queue_check(16'hFFFF, 16'h0000, 1'b0);
    queue_check(16'h1234, 16'h8000, 1'b0);
    queue_op(FUNC_WRITE, 8'(REG_IF), 8'h10);
    queue_op(FUNC_WRITE, 8'(REG_IME), 8'h01);
    queue_check(16'h00A5, 16'h0001, 1'b0);
    queue_op(3'd5, 8'd0, 8'd0);
    queue_op(3'd6, 8'd0, 8'd0);
    queue_op(3'd7, 8'd0, 8'd0);
    wait_drained();

    for (int phase = 0; phase < 4; phase++) begin
      case (phase)
        0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
        1: begin send_idle_pct = 48; recv_stall_pct = 0;  end
        2: begin send_idle_pct = 0;  recv_stall_pct = 48; end
        default: begin send_idle_pct = 28; recv_stall_pct = 28; end
      endcase
      queued_count = 0;
      while (queued_count < ITEMS_PER_PHASE) begin
        if ($urandom_range(99) < 30) queue_dispatch_sequence();
        else queue_random_request();
      end
      wait_drained();
    end

    repeat (SETTLE_CYCLES) @(posedge clk_i);
    if (error_count == 0 && pending_results.size() == 0) begin
      $display("** handheld_timer_interrupt_unit_top: PASSED **");
    end else begin
      $display("** handheld_timer_interrupt_unit_top: FAILED **");
    end
    $finish;
  end

endmodule

### sim.f
rtl/htiu_pkg.sv
rtl/htiu_in_if.sv
rtl/htiu_out_if.sv
rtl/htiu_ctrl.sv
rtl/htiu_dp.sv
rtl/handheld_timer_interrupt_unit_top.sv
bench/tb_handheld_timer_interrupt_unit_top.sv
